### rtl/assert_macros.svh
// Assertion helpers used by dissociated_sumset_extend_top.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold.
`define DSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true.
`define DSE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/dse_pkg.sv
package dse_pkg;

  // Field widths
  localparam int LEVEL_W  = 4;
  localparam int ELEM_W   = 10;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 3;
  localparam int MOD_W    = 11;
  localparam int MOD_REGS = 6;
  localparam int WORD_W   = 64;

  // APB side
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REGIDX_W = 3;

  // Register indexes
  localparam logic [REGIDX_W-1:0] REG_RANK = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_MOD0 = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_MOD1 = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_MOD2 = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_MOD3 = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_MOD4 = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_MOD5 = 3'd6;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_EXTENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COLLISION = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ELEM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_GROUP = 3'd4;

  typedef logic [MOD_W-1:0] modulus_t;

endpackage

### rtl/dse_in_if.sv
interface dse_in_if;
  logic                          valid;
  logic                          ready;
  logic [dse_pkg::LEVEL_W-1:0]   level;
  logic [dse_pkg::ELEM_W-1:0]    element;

  modport source (output valid, level, element, input ready);
  modport sink   (input valid, level, element, output ready);
endinterface

### rtl/dse_out_if.sv
interface dse_out_if;
  logic                          valid;
  logic                          ready;
  logic [dse_pkg::STATUS_W-1:0]  status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

### rtl/dissociated_sumset_extend_top.sv
// Channel  | Dir | Handshake              | Payload
// in_ch    | in  | valid/ready            | level[3:0], element[9:0]
// out_ch   | out | valid/ready            | status[2:0]
// APB      | in  | psel/penable, pready=1 | paddr[4:0], pwdata/prdata[31:0]
//
// One item at a time. Element digits are found by counting, then every group
// index is visited once with one scratch read-modify-write per set bit and a
// source fetch per 64 indexes, then check and copy word passes.
// Reset (rst_n low, synchronous) clears control, sets rank and moduli to 1; masks are unset.
// A finished result waits in the output register while the next item runs.
`include "assert_macros.svh"

module dissociated_sumset_extend_top #(
  parameter int GROUP_ORDER_MAX = 1024,
  parameter int FACTORS_MAX     = 6,
  parameter int LEVELS          = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dse_in_if.sink                         in_ch,
  dse_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dse_pkg::PADDR_W-1:0]    paddr,
  input  logic [dse_pkg::PDATA_W-1:0]    pwdata,
  output logic [dse_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int NF    = (FACTORS_MAX < dse_pkg::MOD_REGS) ? FACTORS_MAX : dse_pkg::MOD_REGS;
  localparam int IW    = (NF > 1) ? $clog2(NF) : 1;
  localparam int MW    = (GROUP_ORDER_MAX + 63) / 64;
  localparam int WW    = (MW > 1) ? $clog2(MW) : 1;
  localparam int IXW   = WW + 7;
  localparam int DW    = $clog2(GROUP_ORDER_MAX);
  localparam int CW    = ((DW > dse_pkg::MOD_W) ? DW : dse_pkg::MOD_W) + 1;
  localparam int DEPTH = LEVELS * MW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PRW   = IXW + dse_pkg::MOD_W;
  localparam int LW    = dse_pkg::LEVEL_W;
  localparam int XW    = dse_pkg::WORD_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCHK = 4'd1;
  localparam logic [3:0] S_ECNT = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SLD  = 4'd4;
  localparam logic [3:0] S_SBIT = 4'd5;
  localparam logic [3:0] S_TWR  = 4'd6;
  localparam logic [3:0] S_CRD  = 4'd7;
  localparam logic [3:0] S_CCHK = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PWR  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // ---------------- configuration ----------------
  logic [dse_pkg::RANK_W-1:0]    rank_r;
  dse_pkg::modulus_t             mod_r [dse_pkg::MOD_REGS];
  logic [dse_pkg::REGIDX_W-1:0]  reg_idx;
  logic                          cfg_wr;

  assign reg_idx = paddr[dse_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= dse_pkg::RANK_W'(1);
      for (int i = 0; i < dse_pkg::MOD_REGS; i++) begin
        mod_r[i] <= dse_pkg::MOD_W'(1);
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        dse_pkg::REG_RANK: rank_r   <= pwdata[dse_pkg::RANK_W-1:0];
        dse_pkg::REG_MOD0: mod_r[0] <= pwdata[dse_pkg::MOD_W-1:0];
        dse_pkg::REG_MOD1: mod_r[1] <= pwdata[dse_pkg::MOD_W-1:0];
        dse_pkg::REG_MOD2: mod_r[2] <= pwdata[dse_pkg::MOD_W-1:0];
        dse_pkg::REG_MOD3: mod_r[3] <= pwdata[dse_pkg::MOD_W-1:0];
        dse_pkg::REG_MOD4: mod_r[4] <= pwdata[dse_pkg::MOD_W-1:0];
        dse_pkg::REG_MOD5: mod_r[5] <= pwdata[dse_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dse_pkg::REG_RANK: prdata = dse_pkg::PDATA_W'(rank_r);
      dse_pkg::REG_MOD0: prdata = dse_pkg::PDATA_W'(mod_r[0]);
      dse_pkg::REG_MOD1: prdata = dse_pkg::PDATA_W'(mod_r[1]);
      dse_pkg::REG_MOD2: prdata = dse_pkg::PDATA_W'(mod_r[2]);
      dse_pkg::REG_MOD3: prdata = dse_pkg::PDATA_W'(mod_r[3]);
      dse_pkg::REG_MOD4: prdata = dse_pkg::PDATA_W'(mod_r[4]);
      dse_pkg::REG_MOD5: prdata = dse_pkg::PDATA_W'(mod_r[5]);
      default:           prdata = '0;
    endcase
  end

  // ---------------- memories ----------------
  logic [XW-1:0] lm_mem [DEPTH];
  logic [XW-1:0] lm_rdata_r;
  logic          lm_re, lm_we;
  logic [AW-1:0] lm_raddr, lm_waddr;
  logic [XW-1:0] lm_wdata;

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lm_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata_r <= lm_mem[lm_raddr];
    end
  end

  // Scratch for the translated mask; per-word valid bits make it empty per item
  logic [XW-1:0] sc_mem [MW];
  logic [XW-1:0] sc_rdata_r;
  logic          sc_rvld_r;
  logic [MW-1:0] sc_vld_r;
  logic          sc_re, sc_we, sc_clr;
  logic [WW-1:0] sc_raddr, sc_waddr;
  logic [XW-1:0] sc_wdata;
  logic [XW-1:0] sc_word;

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    if (sc_re) begin
      sc_rdata_r <= sc_mem[sc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r  <= '0;
      sc_rvld_r <= 1'b0;
    end else begin
      if (sc_clr) begin
        sc_vld_r <= '0;
      end else if (sc_we) begin
        sc_vld_r[sc_waddr] <= 1'b1;
      end
      if (sc_re) begin
        sc_rvld_r <= sc_vld_r[sc_raddr];
      end
    end
  end

  assign sc_word = sc_rvld_r ? sc_rdata_r : '0;

  // Level 0 is the fixed set {0}
  function automatic logic [XW-1:0] src_sel(input logic [LW-1:0] lv,
                                            input logic [WW-1:0] wd,
                                            input logic [XW-1:0] rd);
    logic [XW-1:0] v;
    if (lv == '0) begin
      v = (wd == '0) ? XW'(1) : '0;
    end else begin
      v = rd;
    end
    return v;
  endfunction

  // ---------------- sequencer state ----------------
  logic [3:0]                    state_r, state_nxt;
  logic [LW-1:0]                 lvl_r, lvl_nxt;
  logic [dse_pkg::ELEM_W-1:0]    elem_r, elem_nxt;
  logic [IW-1:0]                 fi_r, fi_nxt;
  logic [IXW-1:0]                n_r, n_nxt;
  logic [IXW-1:0]                w_r [NF];
  logic [IXW-1:0]                w_nxt [NF];
  logic [IXW-1:0]                wu_r [NF];
  logic [IXW-1:0]                wu_nxt [NF];
  logic [DW-1:0]                 td_r [NF];
  logic [DW-1:0]                 td_nxt [NF];
  logic [DW-1:0]                 sd_r [NF];
  logic [DW-1:0]                 sd_nxt [NF];
  logic [IXW-1:0]                s_r, s_nxt;
  logic [IXW-1:0]                tix_r, tix_nxt;
  logic [WW-1:0]                 wc_r, wc_nxt;
  logic [XW-1:0]                 srcw_r, srcw_nxt;
  logic                          clash_r, clash_nxt;
  logic [dse_pkg::STATUS_W-1:0]  res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [dse_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  // Mixed-radix step: one index forward for both digit sets
  logic [DW-1:0]  td_inc [NF];
  logic [DW-1:0]  sd_inc [NF];
  logic [IXW-1:0] tix_inc;

  always_comb begin
    logic          carry;
    logic [DW-1:0] cd;
    logic          t_wrap;
    logic          s_wrap;
    carry   = 1'b1;
    tix_inc = tix_r;
    for (int i = NF - 1; i >= 0; i--) begin
      td_inc[i] = td_r[i];
      sd_inc[i] = sd_r[i];
      cd     = (state_r == S_ECNT) ? td_r[i] : sd_r[i];
      t_wrap = (CW'(td_r[i]) + CW'(1)) == CW'(mod_r[i]);
      s_wrap = (CW'(sd_r[i]) + CW'(1)) == CW'(mod_r[i]);
      if (carry && (32'(i) < 32'(rank_r))) begin
        td_inc[i] = t_wrap ? '0 : td_r[i] + DW'(1);
        sd_inc[i] = s_wrap ? '0 : sd_r[i] + DW'(1);
        tix_inc   = t_wrap ? tix_inc - (wu_r[i] - w_r[i]) : tix_inc + w_r[i];
        carry     = (CW'(cd) + CW'(1)) == CW'(mod_r[i]);
      end
    end
  end

  logic [IXW-1:0] s_plus;
  logic           s_last;
  logic [PRW-1:0] prod_full;
  logic           rank_bad;

  assign s_plus    = s_r + IXW'(1);
  assign s_last    = (s_plus == n_r);
  assign prod_full = PRW'(n_r) * PRW'(mod_r[fi_r]);
  assign rank_bad  = (rank_r == '0) || (32'(rank_r) > dse_pkg::MOD_REGS)
                     || (32'(rank_r) > FACTORS_MAX);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    elem_nxt       = elem_r;
    fi_nxt         = fi_r;
    n_nxt          = n_r;
    w_nxt          = w_r;
    wu_nxt         = wu_r;
    td_nxt         = td_r;
    sd_nxt         = sd_r;
    s_nxt          = s_r;
    tix_nxt        = tix_r;
    wc_nxt         = wc_r;
    srcw_nxt       = srcw_r;
    clash_nxt      = clash_r;
    res_nxt        = res_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    lm_re = 1'b0; lm_raddr = '0;
    lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0;
    sc_re = 1'b0; sc_raddr = '0;
    sc_we = 1'b0; sc_waddr = '0; sc_wdata = '0;
    sc_clr = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          lvl_nxt  = in_ch.level;
          elem_nxt = in_ch.element;
          sc_clr   = 1'b1;
          n_nxt    = IXW'(1);
          fi_nxt   = IW'(rank_r - dse_pkg::RANK_W'(1));
          if (rank_bad) begin
            res_nxt   = dse_pkg::ST_BAD_GROUP;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_GCHK;
          end
        end
      end

      // Group order, least significant factor first; weights on the way
      S_GCHK: begin
        w_nxt[fi_r]  = n_r;
        wu_nxt[fi_r] = IXW'(prod_full);
        n_nxt        = IXW'(prod_full);
        fi_nxt       = fi_r - IW'(1);
        if (mod_r[fi_r] == '0 || prod_full > PRW'(GROUP_ORDER_MAX)) begin
          res_nxt   = dse_pkg::ST_BAD_GROUP;
          state_nxt = S_DONE;
        end else if (fi_r == '0) begin
          if (32'(lvl_r) >= LEVELS) begin
            res_nxt   = dse_pkg::ST_BAD_LEVEL;
            state_nxt = S_DONE;
          end else if (32'(elem_r) >= 32'(prod_full)) begin
            res_nxt   = dse_pkg::ST_BAD_ELEM;
            state_nxt = S_DONE;
          end else begin
            for (int i = 0; i < NF; i++) begin
              td_nxt[i] = '0;
              sd_nxt[i] = '0;
            end
            tix_nxt   = '0;
            s_nxt     = '0;
            state_nxt = S_ECNT;
          end
        end
      end

      // Count up to the element to get its digits
      S_ECNT: begin
        if (32'(tix_r) == 32'(elem_r)) begin
          state_nxt = S_SRD;
        end else begin
          td_nxt  = td_inc;
          tix_nxt = tix_inc;
        end
      end

      S_SRD: begin
        lm_re     = 1'b1;
        lm_raddr  = AW'(32'(lvl_r) * MW + 32'(s_r[WW+5:6]));
        state_nxt = S_SLD;
      end

      S_SLD: begin
        srcw_nxt  = src_sel(lvl_r, s_r[WW+5:6], lm_rdata_r);
        state_nxt = S_SBIT;
      end

      S_SBIT, S_TWR: begin
        if (state_r == S_SBIT && srcw_r[s_r[5:0]]) begin
          // set bit: fetch the target's scratch word
          sc_re     = 1'b1;
          sc_raddr  = tix_r[WW+5:6];
          state_nxt = S_TWR;
        end else begin
          if (state_r == S_TWR) begin
            sc_we    = 1'b1;
            sc_waddr = tix_r[WW+5:6];
            sc_wdata = sc_word | (XW'(1) << tix_r[5:0]);
          end
          if (s_last) begin
            wc_nxt    = '0;
            clash_nxt = 1'b0;
            state_nxt = S_CRD;
          end else begin
            s_nxt     = s_plus;
            sd_nxt    = sd_inc;
            td_nxt    = td_inc;
            tix_nxt   = tix_inc;
            state_nxt = (s_plus[5:0] == '0) ? S_SRD : S_SBIT;
          end
        end
      end

      // Disjointness check; union kept in scratch
      S_CRD: begin
        lm_re     = 1'b1;
        lm_raddr  = AW'(32'(lvl_r) * MW + 32'(wc_r));
        sc_re     = 1'b1;
        sc_raddr  = wc_r;
        state_nxt = S_CCHK;
      end

      S_CCHK: begin
        srcw_nxt  = src_sel(lvl_r, wc_r, lm_rdata_r);
        clash_nxt = clash_r || ((srcw_nxt & sc_word) != '0);
        sc_we     = 1'b1;
        sc_waddr  = wc_r;
        sc_wdata  = srcw_nxt | sc_word;
        if (32'(wc_r) == MW - 1) begin
          wc_nxt = '0;
          if (clash_nxt) begin
            res_nxt   = dse_pkg::ST_COLLISION;
            state_nxt = S_DONE;
          end else if (32'(lvl_r) + 1 < LEVELS) begin
            state_nxt = S_PRD;
          end else begin
            res_nxt   = dse_pkg::ST_EXTENDED;
            state_nxt = S_DONE;
          end
        end else begin
          wc_nxt    = wc_r + WW'(1);
          state_nxt = S_CRD;
        end
      end

      // Copy union to the next level
      S_PRD: begin
        sc_re     = 1'b1;
        sc_raddr  = wc_r;
        state_nxt = S_PWR;
      end

      S_PWR: begin
        lm_we    = 1'b1;
        lm_waddr = AW'((32'(lvl_r) + 1) * MW + 32'(wc_r));
        lm_wdata = sc_word;
        if (32'(wc_r) == MW - 1) begin
          res_nxt   = dse_pkg::ST_EXTENDED;
          state_nxt = S_DONE;
        end else begin
          wc_nxt    = wc_r + WW'(1);
          state_nxt = S_PRD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    elem_r       <= elem_nxt;
    fi_r         <= fi_nxt;
    n_r          <= n_nxt;
    w_r          <= w_nxt;
    wu_r         <= wu_nxt;
    td_r         <= td_nxt;
    sd_r         <= sd_nxt;
    s_r          <= s_nxt;
    tix_r        <= tix_nxt;
    wc_r         <= wc_nxt;
    srcw_r       <= srcw_nxt;
    clash_r      <= clash_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
  end

  // Checks
  `DSE_NEVER(a_no_level0_write, lm_we && (lm_waddr < AW'(MW)), "write into level 0 rows")
  `DSE_ASSERT(a_target_in_group, (state_r == S_TWR) |-> (tix_r < n_r), "target beyond group")
  `DSE_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "stray result")

endmodule

### tb/dissociated_sumset_extend_top_tb.sv
module dissociated_sumset_extend_top_tb;

  localparam int NLEVELS   = 10;
  localparam int ORDER_MAX = 1024;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int HOLD_CYCLES = 3000;

  // Mirror of the block: group config, per-level sum masks, pending statuses
  class sumset_board;
    bit [dse_pkg::RANK_W-1:0]    rank;
    bit [dse_pkg::MOD_W-1:0]     mods[dse_pkg::MOD_REGS];
    bit [ORDER_MAX-1:0]          masks[NLEVELS];
    bit                          written[NLEVELS];
    logic [dse_pkg::STATUS_W-1:0] status_due[$];
    int                          errors;

    function new();
      rank = dse_pkg::RANK_W'(1);
      foreach (mods[i]) mods[i] = dse_pkg::MOD_W'(1);
      foreach (masks[i]) begin
        masks[i] = '0;
        written[i] = 1'b0;
      end
      masks[0][0] = 1'b1;
      written[0] = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] v);
      if (idx == dse_pkg::REG_RANK) rank = v[dse_pkg::RANK_W-1:0];
      else if (idx <= dse_pkg::MOD_REGS) mods[idx-1] = v[dse_pkg::MOD_W-1:0];
    endfunction

    // Group order, 0 when unusable
    function int order();
      int n;
      n = 1;
      if (rank == 0 || rank > dse_pkg::MOD_REGS) return 0;
      for (int i = 0; i < rank; i++) begin
        if (mods[i] == 0) return 0;
        n = n * mods[i];
        if (n > ORDER_MAX) return 0;
      end
      return n;
    endfunction

    // Digit-wise modular sum of two mixed-radix indexes
    function int add_elems(int a, int b);
      int da[dse_pkg::MOD_REGS];
      int db[dse_pkg::MOD_REGS];
      int v;
      int s;
      for (int i = rank - 1; i >= 0; i--) begin
        da[i] = a % mods[i];
        a = a / mods[i];
        db[i] = b % mods[i];
        b = b / mods[i];
      end
      v = 0;
      for (int i = 0; i < rank; i++) begin
        s = da[i] + db[i];
        if (s >= mods[i]) s = s - mods[i];
        v = v * mods[i] + s;
      end
      return v;
    endfunction

    function void note_item(bit [dse_pkg::LEVEL_W-1:0] lvl, bit [dse_pkg::ELEM_W-1:0] el);
      int n;
      bit [ORDER_MAX-1:0] moved;
      n = order();
      moved = '0;
      if (n == 0) status_due.push_back(dse_pkg::ST_BAD_GROUP);
      else if (lvl >= NLEVELS) status_due.push_back(dse_pkg::ST_BAD_LEVEL);
      else if (el >= n) status_due.push_back(dse_pkg::ST_BAD_ELEM);
      else begin
        for (int s = 0; s < n; s++)
          if (masks[lvl][s]) moved[add_elems(s, el)] = 1'b1;
        if ((masks[lvl] & moved) != '0) status_due.push_back(dse_pkg::ST_COLLISION);
        else begin
          if (lvl + 1 < NLEVELS) begin
            masks[lvl+1] = masks[lvl] | moved;
            written[lvl+1] = 1'b1;
          end
          status_due.push_back(dse_pkg::ST_EXTENDED);
        end
      end
    endfunction

    function void check(logic [dse_pkg::STATUS_W-1:0] got);
      logic [dse_pkg::STATUS_W-1:0] want;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got);
        errors++;
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    // Mostly the deepest written level, so chains grow
    function int pick_level();
      int top;
      int lv;
      top = 0;
      for (int i = 0; i < NLEVELS; i++) if (written[i]) top = i;
      if ($urandom_range(0, 1)) return top;
      do lv = $urandom_range(0, top); while (!written[lv]);
      return lv;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [dse_pkg::PADDR_W-1:0] paddr;
  logic [dse_pkg::PDATA_W-1:0] pwdata, prdata;

  dse_in_if  in_ch();
  dse_out_if out_ch();

  dissociated_sumset_extend_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sumset_board sb = new();
  int cycles = 0;
  bit hold_req = 0;
  int burst_left = 0;

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.status);
  end

  // Receiver: windowed stall pattern plus one long hold-off on request
  initial begin
    int hold_cnt;
    int mode;
    hold_cnt = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (rst_n) begin
        if (cycles % 256 == 0) mode = $urandom_range(0, 2);
        if (hold_cnt > 0) begin
          hold_cnt--;
          out_ch.ready = 1'b0;
        end else if (hold_req) begin
          hold_req = 0;
          hold_cnt = HOLD_CYCLES;
          out_ch.ready = 1'b0;
        end else begin
          case (mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = 1'($urandom_range(0, 1));
            default: out_ch.ready = ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  task automatic cfg_write(int idx, bit [31:0] v);
    psel = 1; penable = 0; pwrite = 1;
    paddr = dse_pkg::PADDR_W'(4 * idx);
    pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Wait for all results, then load a full group setting
  task automatic load_group(int r, int m0, int m1, int m2, int m3, int m4, int m5);
    in_ch.valid = 0;
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write(dse_pkg::REG_RANK, r);
    cfg_write(dse_pkg::REG_MOD0, m0);
    cfg_write(dse_pkg::REG_MOD1, m1);
    cfg_write(dse_pkg::REG_MOD2, m2);
    cfg_write(dse_pkg::REG_MOD3, m3);
    cfg_write(dse_pkg::REG_MOD4, m4);
    cfg_write(dse_pkg::REG_MOD5, m5);
  endtask

  // Offer one item in bursts; valid stays high within a burst
  task automatic send_item(int lvl, int el);
    if (burst_left == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid = 1;
    in_ch.level = dse_pkg::LEVEL_W'(lvl);
    in_ch.element = dse_pkg::ELEM_W'(el);
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(in_ch.level, in_ch.element);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic random_item();
    int n;
    int r;
    n = sb.order();
    r = $urandom_range(0, 99);
    if (r < 8) send_item($urandom_range(NLEVELS, 15), $urandom_range(0, 1023));
    else if (r < 16 || n == 0) send_item(sb.pick_level(), $urandom_range(0, 1023));
    else send_item(sb.pick_level(), $urandom_range(0, n - 1));
  endtask

  task automatic random_group(int cap);
    int r;
    int prod;
    int m[dse_pkg::MOD_REGS];
    if ($urandom_range(0, 5) == 0) begin
      foreach (m[i]) m[i] = $urandom_range(0, 2047);
      r = $urandom_range(0, 7);
    end else begin
      r = $urandom_range(1, dse_pkg::MOD_REGS);
      prod = 1;
      foreach (m[i]) begin
        if (i < r) begin
          m[i] = $urandom_range(1, cap / prod);
          prod = prod * m[i];
        end else m[i] = $urandom_range(0, 2047);
      end
    end
    load_group(r, m[0], m[1], m[2], m[3], m[4], m[5]);
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0; in_ch.level = 0; in_ch.element = 0;
    out_ch.ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // Trivial group after reset
    send_item(0, 0);
    send_item(0, 1);
    send_item(15, 0);
    send_item(NLEVELS, 1023);
    // All six factors of order two
    load_group(6, 2, 2, 2, 2, 2, 2);
    send_item(0, 63);
    send_item(1, 63);
    send_item(0, 1023);
    // Largest group: chain up through the top level
    load_group(2, 32, 32, 1, 1, 1, 1);
    for (int i = 0; i < NLEVELS; i++) send_item(i, 1 << i);
    send_item(0, 1023);
    load_group(1, 1024, 1, 1, 1, 1, 1);
    send_item(0, 1023);
    // Unusable groups
    load_group(0, 4, 4, 4, 4, 4, 4);
    send_item(0, 0);
    load_group(7, 2, 2, 2, 2, 2, 2);
    send_item(0, 0);
    load_group(1, 0, 1, 1, 1, 1, 1);
    send_item(0, 0);
    load_group(2, 1024, 2, 1, 1, 1, 1);
    send_item(0, 0);

    // Random phases, small groups mostly
    for (int p = 0; p < 12; p++) begin
      random_group(p == 5 ? 1024 : 128);
      if (p == 3) hold_req = 1;
      repeat (45) random_item();
    end

    in_ch.valid = 0;
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (3300) @(negedge clk);
    if (sb.errors == 0 && sb.status_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/dse_pkg.sv
rtl/dse_in_if.sv
rtl/dse_out_if.sv
rtl/dissociated_sumset_extend_top.sv
tb/dissociated_sumset_extend_top_tb.sv
